// ----- rtl/core/glyph_blitter_with_clock_top_macros.svh -----
// Assertion macros for the glyph blitter.
// Define ASSERT_OFF to compile the checks out.
`ifndef GLYPH_BLITTER_WITH_CLOCK_TOP_MACROS_SVH
`define GLYPH_BLITTER_WITH_CLOCK_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Implication: whenever ante holds, cons holds in the same cycle.
`define GBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Condition that must never hold.
`define GBC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define GBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define GBC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- rtl/core/gbc_pkg.sv -----
package gbc_pkg;

	// default geometry
	localparam int FB_WIDTH_DEF      = 128;
	localparam int SCREEN_HEIGHT_DEF = 96;
	localparam int FONT_GLYPHS_DEF   = 96;

	typedef enum logic [1:0] {
		OP_FONT = 2'd0,
		OP_DRAW = 2'd1,
		OP_TICK = 2'd2,
		OP_READ = 2'd3
	} op_t;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_FONT = 2'd1;
	localparam logic [1:0] STS_CLIP = 2'd2;

	localparam int         FONT_FIRST = 32;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_COLON   = 8'h3a;

	localparam logic [7:0] CELL_MASK = 8'h3f;
	localparam logic [2:0] OFF_SPILL = 3'd2;

	// clock read-out: y fixed, x = 46 - 6*i counted from the right
	localparam logic [6:0] TICK_Y      = 7'd4;
	localparam int         TICK_X0     = 46;
	localparam int         TICK_X_STEP = 6;

	// mixed-radix time digits: tenths, s, 10 s, min, 10 min, 100 min
	localparam int         TICK_DIGITS = 6;
	localparam logic [3:0] DIG_TOP [TICK_DIGITS] = '{4'd9, 4'd9, 4'd5, 4'd9, 4'd9, 4'd9};
	// whole count above the top digit: (2^32-1)/600000 fits in 13 bits
	localparam int         TICK_HI_W = 13;

	function automatic logic [6:0] tick_x(input logic [2:0] i);
		return 7'(TICK_X0 - TICK_X_STEP * int'(i));
	endfunction

	typedef struct packed {
		logic clr_en;
		logic latch;
		logic font_wr;
		logic fb_rd;
		logic rd_cap;
		logic tick_inc;
		logic glyph_start;
		logic flag_bad;
		logic row_rd;
		logic wr0;
		logic wr1;
		logic row_adv;
		logic char_adv;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic glyph_bad;
		logic spill;
		logic row_last;
		logic char_last;
	} sts_t;

endpackage

// ----- rtl/core/gbc_ram.sv -----
module gbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/gbc_ctrl.sv -----
module gbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    opcode,
	output logic          out_valid,
	input  logic          out_stall,
	input  gbc_pkg::sts_t sts,
	output gbc_pkg::cmd_t cmd
);

	import gbc_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_FONT  = 11'b000_0000_0100,
		S_READ  = 11'b000_0000_1000,
		S_RDATA = 11'b000_0001_0000,
		S_TICK  = 11'b000_0010_0000,
		S_START = 11'b000_0100_0000,
		S_ROW   = 11'b000_1000_0000,
		S_WR0   = 11'b001_0000_0000,
		S_WR1   = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d, row_end;
	logic   tick_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// where to go once a glyph row is finished
	always_comb begin
		if (!sts.row_last) begin
			row_end = S_ROW;
		end else if (tick_q && !sts.char_last) begin
			row_end = S_START;
		end else begin
			row_end = S_DONE;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (op_t'(opcode))
						OP_FONT: state_d = S_FONT;
						OP_DRAW: state_d = S_START;
						OP_TICK: state_d = S_TICK;
						OP_READ: state_d = S_READ;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_FONT: begin
				cmd.font_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_READ: begin
				cmd.fb_rd = 1'b1;
				state_d   = S_RDATA;
			end
			S_RDATA: begin
				cmd.rd_cap = 1'b1;
				state_d    = S_DONE;
			end
			S_TICK: begin
				cmd.tick_inc = 1'b1;
				state_d      = S_START;
			end
			S_START: begin
				cmd.glyph_start = 1'b1;
				if (sts.glyph_bad) begin
					cmd.flag_bad = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				cmd.row_rd = 1'b1;
				state_d    = S_WR0;
			end
			S_WR0: begin
				cmd.wr0 = 1'b1;
				if (sts.spill) begin
					state_d = S_WR1;
				end else begin
					cmd.row_adv  = 1'b1;
					cmd.char_adv = sts.row_last;
					state_d      = row_end;
				end
			end
			S_WR1: begin
				cmd.wr1      = 1'b1;
				cmd.row_adv  = 1'b1;
				cmd.char_adv = sts.row_last;
				state_d      = row_end;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			tick_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.latch) begin
				tick_q <= (op_t'(opcode) == OP_TICK);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/gbc_datapath.sv -----
module gbc_datapath #(
	parameter int FB_WIDTH      = gbc_pkg::FB_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gbc_pkg::SCREEN_HEIGHT_DEF,
	parameter int FONT_GLYPHS   = gbc_pkg::FONT_GLYPHS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gbc_pkg::cmd_t cmd,
	output gbc_pkg::sts_t sts,
	input  logic [1:0]    opcode,
	input  logic [7:0]    char_code,
	input  logic [6:0]    x_pos,
	input  logic [6:0]    y_pos,
	input  logic [9:0]    font_index,
	input  logic [7:0]    font_byte,
	input  logic [10:0]   screen_address,
	output logic [7:0]    read_data,
	output logic [1:0]    status
);

	import gbc_pkg::*;

	localparam int ROW_BYTES  = FB_WIDTH / 8;
	localparam int FRAME_SIZE = ROW_BYTES * SCREEN_HEIGHT;
	localparam int FRAME_AW   = $clog2(FRAME_SIZE);
	localparam int FONT_SIZE  = FONT_GLYPHS * 8;
	localparam int FONT_AW    = $clog2(FONT_SIZE);
	localparam int GLYPH_W    = FONT_AW - 3;
	// draw address: y up to 127 plus eight row steps, x/8 and a spill byte
	localparam int WA_W       = $clog2(136 * ROW_BYTES + 2);

	// latched request
	op_t          op_q;
	logic [7:0]   code_q;
	logic [6:0]   x_q, y_q;
	logic [9:0]   fidx_q;
	logic [7:0]   fbyte_q;
	logic [10:0]  sa_q;

	logic [1:0]   stat_q;
	logic [7:0]   rdat_q;
	logic [7:0]   read_data_q;
	logic [1:0]   status_q;

	// glyph walk
	logic [WA_W-1:0]    addr_q, addr1, base_addr;
	logic [2:0]         off_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic [2:0]         row_q;
	logic [2:0]         chr_q;

	// time keeping
	logic [31:0]          tick_q;
	logic [3:0]           dig_q [TICK_DIGITS];
	logic [3:0]           dig_d [TICK_DIGITS];
	logic [TICK_HI_W-1:0] hi_q, hi_d;
	logic                 carry;

	logic [FRAME_AW-1:0] clr_q;

	logic [7:0] sel_code, tick_code;
	logic [6:0] sel_x, sel_y;
	logic       a0_ok, a1_ok, sa_ok, fidx_ok;

	logic [15:0] cell16, bits16;
	logic [7:0]  new_lo, new_hi;

	logic                frm_we, frm_re;
	logic [FRAME_AW-1:0] frm_waddr, frm_raddr;
	logic [7:0]          frm_wdata, frm_q, fnt_q;

	assign addr1   = addr_q + WA_W'(1);
	assign a0_ok   = 32'(addr_q) < FRAME_SIZE;
	assign a1_ok   = 32'(addr1) < FRAME_SIZE;
	assign sa_ok   = 32'(sa_q) < FRAME_SIZE;
	assign fidx_ok = 32'(fidx_q) < FONT_SIZE;

	// character for the current clock position
	always_comb begin
		case (chr_q)
			3'd0: tick_code = CH_ZERO + 8'(dig_q[0]);
			3'd1: tick_code = CH_DOT;
			3'd2: tick_code = CH_ZERO + 8'(dig_q[1]);
			3'd3: tick_code = CH_ZERO + 8'(dig_q[2]);
			3'd4: tick_code = CH_COLON;
			3'd5: tick_code = CH_ZERO + 8'(dig_q[3]);
			3'd6: tick_code = (hi_q == '0 && dig_q[5] == '0 && dig_q[4] == '0) ?
				CH_SPACE : CH_ZERO + 8'(dig_q[4]);
			3'd7: tick_code = (hi_q == '0 && dig_q[5] == '0) ?
				CH_SPACE : CH_ZERO + 8'(dig_q[5]);
			default: tick_code = CH_SPACE;
		endcase
	end

	assign sel_code  = (op_q == OP_TICK) ? tick_code : code_q;
	assign sel_x     = (op_q == OP_TICK) ? tick_x(chr_q) : x_q;
	assign sel_y     = (op_q == OP_TICK) ? TICK_Y : y_q;
	assign base_addr = WA_W'(sel_y) * WA_W'(ROW_BYTES) + WA_W'(sel_x[6:3]);

	assign sts.glyph_bad = (32'(sel_code) < FONT_FIRST) ||
		(32'(sel_code) >= FONT_FIRST + FONT_GLYPHS);
	assign sts.spill     = off_q > OFF_SPILL;
	assign sts.row_last  = &row_q;
	assign sts.char_last = &chr_q;
	assign sts.clr_last  = clr_q == FRAME_AW'(FRAME_SIZE - 1);

	// cell bits set, glyph bits cleared; the upper byte is the spill
	assign cell16 = 16'(CELL_MASK) << off_q;
	assign bits16 = 16'(fnt_q) << off_q;
	assign new_lo = (frm_q | cell16[7:0]) & ~bits16[7:0];
	assign new_hi = (frm_q | cell16[15:8]) & ~bits16[15:8];

	// next time digits, carry rippling up from tenths
	always_comb begin
		carry = 1'b1;
		hi_d  = hi_q;
		for (int k = 0; k < TICK_DIGITS; k++) begin
			dig_d[k] = dig_q[k];
			if (carry) begin
				if (dig_q[k] == DIG_TOP[k]) begin
					dig_d[k] = '0;
				end else begin
					dig_d[k] = dig_q[k] + 4'd1;
					carry    = 1'b0;
				end
			end
		end
		if (carry) begin
			hi_d = hi_q + TICK_HI_W'(1);
		end
	end

	// framebuffer port
	assign frm_we    = cmd.clr_en | (cmd.wr0 & a0_ok) | (cmd.wr1 & a1_ok);
	assign frm_waddr = cmd.clr_en ? clr_q : (cmd.wr1 ? FRAME_AW'(addr1) : FRAME_AW'(addr_q));
	assign frm_wdata = cmd.clr_en ? 8'd0 : (cmd.wr1 ? new_hi : new_lo);
	assign frm_re    = (cmd.fb_rd & sa_ok) | (cmd.row_rd & a0_ok) |
		(cmd.wr0 & sts.spill & a1_ok);
	assign frm_raddr = cmd.fb_rd ? FRAME_AW'(sa_q) :
		(cmd.wr0 ? FRAME_AW'(addr1) : FRAME_AW'(addr_q));

	gbc_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_SIZE)
	) u_frame (
		.clk   (clk),
		.we    (frm_we),
		.waddr (frm_waddr),
		.wdata (frm_wdata),
		.re    (frm_re),
		.raddr (frm_raddr),
		.rdata (frm_q)
	);

	gbc_ram #(
		.WIDTH (8),
		.DEPTH (FONT_SIZE)
	) u_font (
		.clk   (clk),
		.we    (cmd.font_wr & fidx_ok),
		.waddr (FONT_AW'(fidx_q)),
		.wdata (fbyte_q),
		.re    (cmd.row_rd),
		.raddr ({glyph_q, row_q}),
		.rdata (fnt_q)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			tick_q <= '0;
			dig_q  <= '{default: '0};
			hi_q   <= '0;
			row_q  <= '0;
			chr_q  <= '0;
		end else begin
			if (cmd.clr_en) begin
				clr_q <= clr_q + FRAME_AW'(1);
			end
			if (cmd.tick_inc) begin
				tick_q <= tick_q + 32'd1;
				chr_q  <= '0;
				if (&tick_q) begin
					dig_q <= '{default: '0};
					hi_q  <= '0;
				end else begin
					dig_q <= dig_d;
					hi_q  <= hi_d;
				end
			end else if (cmd.char_adv) begin
				chr_q <= chr_q + 3'd1;
			end
			if (cmd.glyph_start) begin
				row_q <= '0;
			end else if (cmd.row_adv) begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op_t'(opcode);
			code_q  <= char_code;
			x_q     <= x_pos;
			y_q     <= y_pos;
			fidx_q  <= font_index;
			fbyte_q <= font_byte;
			sa_q    <= screen_address;
			stat_q  <= STS_OK;
			rdat_q  <= 8'd0;
		end
		if (cmd.font_wr && !fidx_ok) begin
			stat_q <= STS_CLIP;
		end
		if (cmd.rd_cap) begin
			if (sa_ok) begin
				rdat_q <= frm_q;
			end else begin
				stat_q <= STS_CLIP;
			end
		end
		if (cmd.flag_bad) begin
			stat_q <= STS_FONT;
		end
		if ((cmd.wr0 && !a0_ok) || (cmd.wr1 && !a1_ok)) begin
			stat_q <= STS_CLIP;
		end
		if (cmd.glyph_start) begin
			addr_q  <= base_addr;
			off_q   <= sel_x[2:0];
			glyph_q <= GLYPH_W'(32'(sel_code) - FONT_FIRST);
		end else if (cmd.row_adv) begin
			addr_q <= addr_q + WA_W'(ROW_BYTES);
		end
		if (cmd.out_load) begin
			read_data_q <= rdat_q;
			status_q    <= stat_q;
		end
	end

	assign read_data = read_data_q;
	assign status    = status_q;

endmodule

// ----- rtl/core/glyph_blitter_with_clock_top.sv -----
// Font load writes the font byte; framebuffer read reads, then captures it; draw
// walks a glyph's eight rows; clock tick steps the time, then draws eight glyphs,
// four of which spill into a second byte. One request at a time; the next is taken
// in the cycle after a result is handed to the output register. A glyph row is a
// read and a write step, plus a second write step for a spill byte (one write port).
// Reset clears the framebuffer one byte a cycle (1536 bytes at default size).
`include "glyph_blitter_with_clock_top_macros.svh"

module glyph_blitter_with_clock_top #(
	parameter int FB_WIDTH      = gbc_pkg::FB_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gbc_pkg::SCREEN_HEIGHT_DEF,
	parameter int FONT_GLYPHS   = gbc_pkg::FONT_GLYPHS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [6:0]  x_pos,
	input  logic [6:0]  y_pos,
	input  logic [9:0]  font_index,
	input  logic [7:0]  font_byte,
	input  logic [10:0] screen_address,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [1:0]  status
);

	import gbc_pkg::*;

	// Controller steps the request through clear, load, read, or glyph rows;
	// the datapath holds the request, the time digits and both stores.
	cmd_t cmd;
	sts_t sts;

	gbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Glyph row: font and framebuffer read together, then the modified byte
	// is written back while the spill byte (bit offset above two) is read.
	// The clock read-out walks eight characters right to left, taking its
	// digits from a mixed-radix counter kept beside the binary tick count.
	gbc_datapath #(
		.FB_WIDTH      (FB_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.FONT_GLYPHS   (FONT_GLYPHS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.char_code      (char_code),
		.x_pos          (x_pos),
		.y_pos          (y_pos),
		.font_index     (font_index),
		.font_byte      (font_byte),
		.screen_address (screen_address),
		.read_data      (read_data),
		.status         (status)
	);

	// no request is taken during the clearing pass
	`GBC_ASSERT_IMP(a_clear_stall, clk, arst_n, cmd.clr_en, in_stall && !out_valid, "request during clear")
	// a finished result never overwrites one still waiting
	`GBC_ASSERT_IMP(a_no_overrun, clk, arst_n, cmd.out_load, !out_valid || !out_stall, "result overrun")
	// write-back comes in the cycle after its read
	`GBC_ASSERT_IMP(a_wr0_after_rd, clk, arst_n, cmd.wr0, $past(cmd.row_rd), "write without read")
	`GBC_ASSERT_IMP(a_wr1_after_wr0, clk, arst_n, cmd.wr1, $past(cmd.wr0), "spill out of order")
	// only one framebuffer writer at a time
	`GBC_ASSERT_NEVER(a_one_writer, clk, arst_n, cmd.clr_en && (cmd.wr0 || cmd.wr1), "write clash")

endmodule
